[hdl/iapd_pkg.sv]
// shared constants and types for the average-of-up-and-left dpcm differencer
package iapd_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int PIX_W = 8;
    localparam int DIM_W = 10;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    // effective dimension widths hold both the register value and the maximum
    localparam int WCNT_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int HCNT_W = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(474);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(264);

    typedef enum logic [1:0] {
        PRED_ZERO,
        PRED_LEFT,
        PRED_UP,
        PRED_AVG
    } t_pred_sel;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] left;
        t_pred_sel        sel;
        logic             frame_end;
    } t_item;

endpackage

[hdl/image_average_predictor_diff.sv]
// a pixel passes the front-end register, a queue entry and the output register on its way out
// throughput: one pixel per cycle, set by the single read and write line store in the front end
// when the queue has room; a 4-beat queue lets the front end keep accepting while output stalls
// reset (synchronous, active low) clears counters, left pixel, queue and valids
// width and height registers reset to 474 and 264; the line store has no reset
module image_average_predictor_diff (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [iapd_pkg::PIX_W-1:0]          i_pixel,
    // residual output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [iapd_pkg::PIX_W-1:0]          o_residual,
    output logic                                o_frame_end,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iapd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iapd_pkg::DIM_W-1:0]          i_cfg_data
);
    import iapd_pkg::*;

    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [WCNT_W-1:0] eff_width;
    logic [HCNT_W-1:0] eff_height;

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_item front_item;
    t_item head_item;

    // configuration registers, always ready to take a beat
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, values above the line store size saturate
    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = WCNT_W'(1);
        end else if (WCNT_W'(r_frame_width) > WCNT_W'(MAX_WIDTH)) begin
            eff_width = WCNT_W'(MAX_WIDTH);
        end else begin
            eff_width = WCNT_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_height = HCNT_W'(1);
        end else if (HCNT_W'(r_frame_height) > HCNT_W'(MAX_HEIGHT)) begin
            eff_height = HCNT_W'(MAX_HEIGHT);
        end else begin
            eff_height = HCNT_W'(r_frame_height);
        end
    end

    // front end: counts position, reads the pixel above, picks the predictor
    iapd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel      (i_pixel),
        .i_eff_width  (eff_width),
        .i_eff_height (eff_height),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    // decoupling queue
    iapd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (front_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_empty     (q_empty),
        .o_head      (head_item)
    );

    // back end: averages, subtracts modulo 256 and holds the result beat
    iapd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_residual  (o_residual),
        .o_frame_end (o_frame_end)
    );

endmodule

[hdl/iapd_front.sv]
// front end: raster counters, line store, left neighbor and prediction class
module iapd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [iapd_pkg::PIX_W-1:0]    i_pixel,
    input  logic [iapd_pkg::WCNT_W-1:0]   i_eff_width,
    input  logic [iapd_pkg::HCNT_W-1:0]   i_eff_height,
    input  logic                          i_q_full,
    output logic                          o_push,
    output iapd_pkg::t_item               o_item
);
    import iapd_pkg::*;

    logic [PIX_W-1:0] r_line [MAX_WIDTH];

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_up;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [PIX_W-1:0] r_s1_left;
    t_pred_sel        r_s1_sel;
    logic             r_s1_frame_end;

    logic      accept;
    logic      row_end;
    logic      frame_end;
    t_pred_sel sel;

    assign o_in_stall = r_s1_valid && i_q_full;
    assign o_push     = r_s1_valid && !i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    assign row_end   = (WCNT_W'(r_col) + WCNT_W'(1)) >= i_eff_width;
    assign frame_end = row_end && ((HCNT_W'(r_row) + HCNT_W'(1)) >= i_eff_height);

    always_comb begin
        if (r_row != '0 && r_col != '0) begin
            sel = PRED_AVG;
        end else if (r_row != '0) begin
            sel = PRED_UP;
        end else if (r_col != '0) begin
            sel = PRED_LEFT;
        end else begin
            sel = PRED_ZERO;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    // line store: old entry read and new pixel written at the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up         <= r_line[r_col];
            r_line[r_col] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_left     <= i_pixel;
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel     <= i_pixel;
            r_s1_left      <= r_left;
            r_s1_sel       <= sel;
            r_s1_frame_end <= frame_end;
        end
    end

    always_comb begin
        o_item.pixel     = r_s1_pixel;
        o_item.up        = r_up;
        o_item.left      = r_s1_left;
        o_item.sel       = r_s1_sel;
        o_item.frame_end = r_s1_frame_end;
    end

endmodule

[hdl/iapd_queue.sv]
// small fifo between the front end and the back end
module iapd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iapd_pkg::t_item i_push_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output iapd_pkg::t_item o_head
);
    import iapd_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

[hdl/iapd_back.sv]
// back end: prediction, residual and output register
module iapd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  iapd_pkg::t_item            i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [iapd_pkg::PIX_W-1:0] o_residual,
    output logic                       o_frame_end
);
    import iapd_pkg::*;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_residual;
    logic             r_frame_end;

    logic [PIX_W:0]   sum;
    logic [PIX_W-1:0] pred;

    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);
    assign sum   = {1'b0, i_head.up} + {1'b0, i_head.left};

    always_comb begin
        case (i_head.sel)
            PRED_AVG:  pred = sum[PIX_W:1];
            PRED_UP:   pred = i_head.up;
            PRED_LEFT: pred = i_head.left;
            default:   pred = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_residual  <= i_head.pixel - pred;
            r_frame_end <= i_head.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_residual  = r_residual;
    assign o_frame_end = r_frame_end;

endmodule

[hdl/iapd_checker.sv]
// port-level checker for the differencer, bound to the top level
module iapd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [iapd_pkg::PIX_W-1:0]         o_residual,
    input logic                               o_frame_end
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) |->
            o_out_valid && $stable(o_residual) && $stable(o_frame_end))
        else $error("result beat changed while stalled");

    // nothing pending right after a reset edge
    a_reset_clear: assert property (@(posedge i_clk)
        (!i_rst_n ##1 1'b1) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // input backpressure only follows output backpressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output stall");

    // a result leaving an empty pipeline must come from an earlier taken pixel
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 3))
        else $error("result without matching input beat");

endmodule

bind image_average_predictor_diff iapd_checker u_iapd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_residual  (o_residual),
    .o_frame_end (o_frame_end)
);

[test/tb_image_average_predictor_diff.sv]
// self-checking testbench for the average-of-up-and-left dpcm differencer
`timescale 1ns / 100ps

module tb_image_average_predictor_diff;
    import iapd_pkg::*;

    // one expected result beat
    typedef struct packed {
        logic [PIX_W-1:0] residual;
        logic             frame_end;
    } t_residual;

    // how the pixel values of one run are shaped
    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_SMOOTH,
        PIX_FLAT
    } t_pix_style;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [PIX_W-1:0]     in_pixel  = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [DIM_W-1:0]     cfg_data  = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [PIX_W-1:0]     o_residual;
    logic                 o_frame_end;
    logic                 o_cfg_ready;

    // pixels waiting for the driver, residuals waiting for the monitor
    logic [PIX_W-1:0] pixel_q [$];
    t_residual        residual_q [$];

    int err_cnt   = 0;
    int idle_pct  = 0;   // chance per beat that the sender starts a gap
    int stall_pct = 0;   // chance per cycle that the receiver starts a stall
    int gap_left  = 0;
    int stall_left = 0;

    // differencer state mirrored in the testbench
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] left_px    = '0;
    int               col_q      = 0;
    int               row_q      = 0;
    logic [DIM_W-1:0] width_reg  = FRAME_WIDTH_RST;
    logic [DIM_W-1:0] height_reg = FRAME_HEIGHT_RST;
    int               filled     = 0;   // line-store entries written since reset, always a prefix

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    image_average_predictor_diff dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (in_pixel),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_residual  (o_residual),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // zero acts as one, anything above the maximum saturates
    function automatic int eff_dim(input logic [DIM_W-1:0] raw, input int hi);
        if (raw == '0)
            return 1;
        if (int'(raw) > hi)
            return hi;
        return int'(raw);
    endfunction

    // a width that grows mid-frame must not reach entries the line store never got
    function automatic logic [DIM_W-1:0] safe_width(input logic [DIM_W-1:0] raw);
        if (row_q != 0 && eff_dim(raw, MAX_WIDTH) > filled)
            return DIM_W'(filled);
        return raw;
    endfunction

    // residual of one accepted pixel, then advance the mirrored state
    task automatic predict_residual(input logic [PIX_W-1:0] px);
        logic [PIX_W-1:0] up;
        logic [PIX_W:0]   sum;
        logic [PIX_W-1:0] pred;
        logic [PIX_W-1:0] res;
        t_pred_sel        sel;
        bit               row_end;
        bit               fend;
        up  = line_mem[COL_W'(col_q)];
        sum = {1'b0, up} + {1'b0, left_px};
        if (row_q > 0 && col_q > 0)
            sel = PRED_AVG;
        else if (row_q > 0)
            sel = PRED_UP;
        else if (col_q > 0)
            sel = PRED_LEFT;
        else
            sel = PRED_ZERO;
        case (sel)
            PRED_AVG:  pred = sum[PIX_W:1];   // floor of the mean
            PRED_UP:   pred = up;
            PRED_LEFT: pred = left_px;
            default:   pred = '0;
        endcase
        res = px - pred;                      // wraps modulo 256
        line_mem[COL_W'(col_q)] = px;
        left_px = px;
        if (col_q + 1 > filled)
            filled = col_q + 1;
        // counters are kept across register writes, so compare with >=
        row_end = (col_q + 1) >= eff_dim(width_reg, MAX_WIDTH);
        fend    = row_end && (row_q + 1) >= eff_dim(height_reg, MAX_HEIGHT);
        if (row_end) begin
            col_q = 0;
            row_q = fend ? 0 : row_q + 1;
        end else begin
            col_q = col_q + 1;
        end
        residual_q.push_back('{residual: res, frame_end: fend});
    endtask

    // pixel driver: holds a beat until taken, inserts random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall)
                predict_residual(in_pixel);
            // payload may only change once the current beat is gone
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pixel_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    // start an idle gap of random length, this cycle included
                    gap_left = $urandom_range(13);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_pixel <= pixel_q.pop_front();
                end
            end
        end
    end

    // residual monitor: compares each taken beat, stalls in random bursts
    always @(posedge clk) begin
        t_residual exp_res;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (residual_q.size() == 0) begin
                    $error("residual %0d frame_end %0d with no pixel pending",
                           o_residual, o_frame_end);
                    err_cnt++;
                end else begin
                    exp_res = residual_q.pop_front();
                    if (o_residual !== exp_res.residual) begin
                        $error("residual: expected %0d, actual %0d",
                               exp_res.residual, o_residual);
                        err_cnt++;
                    end
                    if (o_frame_end !== exp_res.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               exp_res.frame_end, o_frame_end);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(13);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // register write over the config channel, mirrored at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        @(negedge clk);
        while (pixel_q.size() != 0 || in_valid || residual_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic push_pixels(input int n, input t_pix_style style);
        logic [PIX_W-1:0] px;
        px = PIX_W'($urandom_range(255));
        repeat (n) begin
            case (style)
                PIX_UNIFORM: px = PIX_W'($urandom_range(255));
                PIX_EXTREME: begin
                    case ($urandom_range(3))
                        0:       px = 8'h00;
                        1:       px = 8'hff;
                        2:       px = 8'h80;
                        default: px = 8'h7f;
                    endcase
                end
                PIX_SMOOTH: px = PIX_W'(int'(px) + int'($urandom_range(6)) - 3);
                default: begin
                    // mostly flat with an occasional step
                    if ($urandom_range(7) == 0)
                        px = PIX_W'($urandom_range(255));
                end
            endcase
            pixel_q.push_back(px);
        end
    endtask

    function automatic int pick_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    initial begin : stimulus
        logic [PIX_W-1:0] corner_frame [9];
        logic [DIM_W-1:0] w_raw;
        logic [DIM_W-1:0] h_raw;
        int               rand_items;
        int               phase;
        int               n;
        int               area;
        int               r;
        bit               do_w;
        bit               do_h;

        // 3x3 frame: top-left, first row, first column, interior, wrap both ways,
        // odd sum so the mean rounds down
        corner_frame = '{8'd255, 8'd0, 8'd255,
                         8'd0, 8'd255, 8'd0,
                         8'd255, 8'd255, 8'd0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small full frame
        write_reg(CFG_FRAME_WIDTH, 10'd3);
        write_reg(CFG_FRAME_HEIGHT, 10'd3);
        @(negedge clk);
        foreach (corner_frame[i])
            pixel_q.push_back(corner_frame[i]);

        // zero width and height act as one: every pixel ends a frame
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 10'd0);
        write_reg(CFG_FRAME_HEIGHT, 10'd0);
        @(negedge clk);
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd255);

        // single column: only the pixel above predicts
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 10'd1);
        write_reg(CFG_FRAME_HEIGHT, 10'd3);
        @(negedge clk);
        pixel_q.push_back(8'd200);
        pixel_q.push_back(8'd100);
        pixel_q.push_back(8'd7);

        // single row: only the left pixel predicts
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 10'd4);
        write_reg(CFG_FRAME_HEIGHT, 10'd1);
        @(negedge clk);
        pixel_q.push_back(8'd1);
        pixel_q.push_back(8'd2);
        pixel_q.push_back(8'd254);
        pixel_q.push_back(8'd128);

        // random phases; the first two are the saturating extremes
        rand_items = 0;
        phase = 0;
        while (rand_items < 1370) begin
            wait_drained();
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            if (phase == 0) begin
                // width above the maximum: one row of 512 fills the whole line store
                write_reg(CFG_FRAME_WIDTH, 10'd1023);
                write_reg(CFG_FRAME_HEIGHT, 10'd1);
                @(negedge clk);
                push_pixels(MAX_WIDTH, PIX_UNIFORM);
                rand_items += MAX_WIDTH;
            end else if (phase == 1) begin
                // height above the maximum: one column of 512 rows
                write_reg(CFG_FRAME_WIDTH, 10'd1);
                write_reg(CFG_FRAME_HEIGHT, 10'd1023);
                @(negedge clk);
                push_pixels(MAX_HEIGHT, t_pix_style'($urandom_range(3)));
                rand_items += MAX_HEIGHT;
            end else begin
                r = $urandom_range(99);
                if (r < 70)
                    w_raw = DIM_W'($urandom_range(1, 16));
                else if (r < 78)
                    w_raw = '0;
                else if (r < 90)
                    w_raw = DIM_W'($urandom_range(17, 512));
                else
                    w_raw = DIM_W'($urandom_range(513, 1023));
                r = $urandom_range(99);
                if (r < 70)
                    h_raw = DIM_W'($urandom_range(1, 8));
                else if (r < 78)
                    h_raw = '0;
                else if (r < 90)
                    h_raw = DIM_W'($urandom_range(9, 64));
                else
                    h_raw = DIM_W'($urandom_range(65, 1023));
                // sometimes only one register, sometimes none: counters run on mid-frame
                do_w = $urandom_range(9) != 0;
                do_h = $urandom_range(9) != 0;
                if ($urandom_range(1)) begin
                    if (do_h)
                        write_reg(CFG_FRAME_HEIGHT, h_raw);
                    if (do_w)
                        write_reg(CFG_FRAME_WIDTH, safe_width(w_raw));
                end else begin
                    if (do_w)
                        write_reg(CFG_FRAME_WIDTH, safe_width(w_raw));
                    if (do_h)
                        write_reg(CFG_FRAME_HEIGHT, h_raw);
                end
                area = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
                // whole frames mostly, partial frames now and then
                if (area > 120 || $urandom_range(99) < 30)
                    n = $urandom_range(1, 40);
                else
                    n = area * $urandom_range(1, 2);
                @(negedge clk);
                push_pixels(n, t_pix_style'($urandom_range(3)));
                rand_items += n;
            end
            phase++;
        end

        // closing stretch at full rate on both sides
        wait_drained();
        idle_pct  = 0;
        stall_pct = 0;
        // let any leftover gap or stall burst run out first
        while (gap_left != 0 || stall_left != 0)
            @(negedge clk);
        write_reg(CFG_FRAME_WIDTH, safe_width(10'd5));
        write_reg(CFG_FRAME_HEIGHT, 10'd4);
        @(negedge clk);
        push_pixels(60, PIX_UNIFORM);

        wait_drained();
        // room for any stray beat to show up
        repeat (16) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hdl/iapd_pkg.sv
hdl/iapd_front.sv
hdl/iapd_queue.sv
hdl/iapd_back.sv
hdl/image_average_predictor_diff.sv
hdl/iapd_checker.sv
test/tb_image_average_predictor_diff.sv
